>>> hw/rtl/assert_macros.svh
// Assertion helpers, included by cigar_clip_elements to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk_i outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/cce_pkg.sv
package cce_pkg;

  localparam int unsigned ELEM_OP_W  = 4;
  localparam int unsigned ELEM_LEN_W = 28;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [ELEM_OP_W-1:0] OP_MATCH = 4'd0;
  localparam logic [ELEM_OP_W-1:0] OP_INS   = 4'd1;
  localparam logic [ELEM_OP_W-1:0] OP_DEL   = 4'd2;
  localparam logic [ELEM_OP_W-1:0] OP_SKIP  = 4'd3;
  localparam logic [ELEM_OP_W-1:0] OP_SOFT  = 4'd4;
  localparam logic [ELEM_OP_W-1:0] OP_HARD  = 4'd5;
  localparam logic [ELEM_OP_W-1:0] OP_PAD   = 4'd6;
  localparam logic [ELEM_OP_W-1:0] OP_EQUAL = 4'd7;
  localparam logic [ELEM_OP_W-1:0] OP_DIFF  = 4'd8;
  localparam logic [ELEM_OP_W-1:0] OP_NONE  = 4'd0;

  typedef enum logic [1:0] {
    REG_CLIP_START = 2'd0,
    REG_CLIP_STOP  = 2'd1,
    REG_CLIP_HARD  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] clip_start;
    logic [CFG_W-1:0] clip_stop;
    logic             clip_hard;
  } cfg_t;

  function automatic logic eats_read(input logic [ELEM_OP_W-1:0] op);
    logic r;
    case (op)
      OP_MATCH, OP_INS, OP_SOFT, OP_EQUAL, OP_DIFF: r = 1'b1;
      default:                                      r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/cce_if.sv
interface cce_elem_if;
  import cce_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ELEM_OP_W-1:0]  elem_op;
  logic [ELEM_LEN_W-1:0] elem_len;
  logic                  elem_final;

  modport source (output valid, output elem_op, output elem_len, output elem_final,
                  input ready);
  modport sink   (input valid, input elem_op, input elem_len, input elem_final,
                  output ready);
endinterface

interface cce_piece_if;
  import cce_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  piece_valid;
  logic [ELEM_OP_W-1:0]  piece_op;
  logic [ELEM_LEN_W-1:0] piece_len;
  logic                  run_last;
  logic                  string_end;

  modport source (output valid, output piece_valid, output piece_op, output piece_len,
                  output run_last, output string_end, input ready);
  modport sink   (input valid, input piece_valid, input piece_op, input piece_len,
                  input run_last, input string_end, output ready);
endinterface

>>> hw/rtl/cce_regs.sv
module cce_regs import cce_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_CLIP_START: cfg_d.clip_start = pwdata[CFG_W-1:0];
        REG_CLIP_STOP:  cfg_d.clip_stop  = pwdata[CFG_W-1:0];
        REG_CLIP_HARD:  cfg_d.clip_hard  = pwdata[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CLIP_START: prdata = APB_DATA_W'(cfg_q.clip_start);
      REG_CLIP_STOP:  prdata = APB_DATA_W'(cfg_q.clip_stop);
      REG_CLIP_HARD:  prdata = APB_DATA_W'(cfg_q.clip_hard);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> hw/rtl/cce_front.sv
module cce_front import cce_pkg::*; #(
  parameter int unsigned LEN_BITS = 28,
  parameter int unsigned POS_BITS = 32,
  parameter int unsigned ENTRY_W  = ELEM_OP_W + LEN_BITS + 1 + 2 * POS_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  cce_elem_if.sink           elem,
  output logic               push_valid_o,
  output logic [ENTRY_W-1:0] push_data_o,
  input  logic               push_ready_i,
  output logic [POS_BITS-1:0] pos_o
);

  localparam int unsigned SUM_W = ((POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS) + 1;

  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [LEN_BITS-1:0] len;
  logic [SUM_W-1:0]    sum;
  logic [POS_BITS-1:0] pos_end;
  logic                accept;

  assign elem.ready   = push_ready_i;
  assign accept       = elem.valid & push_ready_i;
  assign push_valid_o = elem.valid;
  assign pos_o        = pos_q;

  assign len = elem.elem_len[LEN_BITS-1:0];
  assign sum = SUM_W'(pos_q) + SUM_W'(len);

  // The position saturates rather than wrapping.
  always_comb begin
    if (!eats_read(elem.elem_op)) begin
      pos_end = pos_q;
    end else if (|sum[SUM_W-1:POS_BITS]) begin
      pos_end = '1;
    end else begin
      pos_end = sum[POS_BITS-1:0];
    end
  end

  assign push_data_o = {elem.elem_op, len, elem.elem_final, pos_q, pos_end};

  always_comb begin
    pos_d = pos_q;
    if (accept) begin
      if (elem.elem_final) begin
        pos_d = '0;
      end else if (elem.elem_op != OP_HARD) begin
        pos_d = pos_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

>>> hw/rtl/cce_fifo.sv
module cce_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             push_ready_o,
  output logic             pop_valid_o,
  output logic [WIDTH-1:0] pop_data_o,
  input  logic             pop_ready_i
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_FULL);
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> hw/rtl/cce_back.sv
module cce_back import cce_pkg::*; #(
  parameter int unsigned LEN_BITS = 28,
  parameter int unsigned POS_BITS = 32,
  parameter int unsigned ENTRY_W  = ELEM_OP_W + LEN_BITS + 1 + 2 * POS_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               pop_valid_i,
  input  logic [ENTRY_W-1:0] pop_data_i,
  output logic               pop_ready_o,
  cce_piece_if.source        piece
);

  localparam int unsigned CMP_W = (POS_BITS > CFG_W) ? POS_BITS : CFG_W;

  logic [ELEM_OP_W-1:0] op;
  logic [LEN_BITS-1:0]  len;
  logic                 fin;
  logic [POS_BITS-1:0]  pos_s, pos_e;
  logic [CMP_W-1:0]     s_w, e_w, cs_w, ce_w;
  logic [LEN_BITS-1:0]  kept;
  logic [ELEM_OP_W-1:0] cop;
  logic                 eats, left, outside, total;

  logic [1:0]           n;
  logic [ELEM_OP_W-1:0] p0_op, p1_op;
  logic [LEN_BITS-1:0]  p0_len, p1_len;
  logic                 marker;

  logic                 job_valid_q, job_valid_d;
  logic                 two_q, idx_q, idx_d;
  logic                 marker_q, final_q;
  logic [ELEM_OP_W-1:0] p0_op_q, p1_op_q;
  logic [LEN_BITS-1:0]  p0_len_q, p1_len_q;
  logic                 last, load, out_xfer;

  assign {op, len, fin, pos_s, pos_e} = pop_data_i;

  assign s_w  = CMP_W'(pos_s);
  assign e_w  = CMP_W'(pos_e);
  assign cs_w = CMP_W'(cfg_i.clip_start);
  assign ce_w = CMP_W'(cfg_i.clip_stop);

  assign eats    = eats_read(op);
  assign left    = (cfg_i.clip_start == '0);
  assign cop     = cfg_i.clip_hard ? OP_HARD : OP_SOFT;
  assign outside = (e_w <= cs_w) || (s_w >= ce_w);
  assign total   = left ? (e_w <= ce_w) : (cs_w <= s_w);

  always_comb begin
    if (left) begin
      kept = LEN_BITS'(e_w - ce_w);
    end else begin
      kept = LEN_BITS'(cs_w - s_w);
    end
  end

  always_comb begin
    n      = 2'd0;
    p0_op  = op;
    p0_len = len;
    p1_op  = op;
    p1_len = kept;
    marker = 1'b0;
    if (op == OP_HARD) begin
      n = 2'd1;
    end else if (outside) begin
      // A non-consuming element sitting exactly on a span edge is dropped.
      if (eats || ((s_w != cs_w) && (s_w != ce_w))) begin
        n = 2'd1;
      end
    end else if (total) begin
      if (eats) begin
        n     = 2'd1;
        p0_op = cop;
      end
    end else if (left) begin
      n      = 2'd2;
      p0_op  = cop;
      p0_len = len - kept;
    end else begin
      n      = 2'd2;
      p0_len = kept;
      p1_op  = cop;
      p1_len = len - kept;
    end
    if (fin && (n == 2'd0)) begin
      n      = 2'd1;
      marker = 1'b1;
      p0_op  = OP_NONE;
      p0_len = '0;
    end
  end

  assign last     = !two_q || idx_q;
  assign out_xfer = job_valid_q & piece.ready;
  assign load     = !job_valid_q || (out_xfer && last);
  assign pop_ready_o = load;

  always_comb begin
    job_valid_d = job_valid_q;
    idx_d       = idx_q;
    if (load) begin
      job_valid_d = pop_valid_i && (n != 2'd0);
      idx_d       = 1'b0;
    end else if (out_xfer) begin
      idx_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && pop_valid_i) begin
      two_q    <= (n == 2'd2);
      marker_q <= marker;
      final_q  <= fin;
      p0_op_q  <= p0_op;
      p0_len_q <= p0_len;
      p1_op_q  <= p1_op;
      p1_len_q <= p1_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      idx_q       <= idx_d;
    end
  end

  assign piece.valid       = job_valid_q;
  assign piece.piece_valid = !marker_q;
  assign piece.piece_op    = idx_q ? p1_op_q : p0_op_q;
  assign piece.piece_len   = ELEM_LEN_W'(idx_q ? p1_len_q : p0_len_q);
  assign piece.run_last    = last;
  assign piece.string_end  = final_q & last;

endmodule

>>> hw/rtl/cigar_clip_elements.sv
// Clips a span of read positions out of a CIGAR string that arrives one
// element per transfer on the elem channel; the pieces leave on the piece
// channel, each flagged with run_last on the last piece of its element and
// string_end on the last piece of the string. A final element that yields
// nothing produces one end-only marker with piece_valid low.
// The clip window and clip type are written through the APB port at byte
// addresses 0, 4 and 8; the user must write them only while no element is
// in flight, which the block does not enforce. The front stage tracks the
// running read position and queues each element; the back stage classifies
// it against the window and emits its pieces. An accepted element is written
// into the queue, then loaded into the piece registers of the back stage.
// The back stage loads a new element as the last pending piece leaves.
// Reset clears the read position, the queue, the pending pieces and all three
// registers. When the receiver stalls, the current piece holds, the queue
// fills and elem.ready falls once it is full.
module cigar_clip_elements import cce_pkg::*; #(
  parameter int unsigned LEN_BITS    = 28,
  parameter int unsigned POS_BITS    = 32,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  cce_elem_if.sink              elem,
  cce_piece_if.source           piece,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned ENTRY_W = ELEM_OP_W + LEN_BITS + 1 + 2 * POS_BITS;

  cfg_t                cfg;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0]  push_data, pop_data;
  logic [POS_BITS-1:0] pos;

  cce_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cce_front #(
    .LEN_BITS (LEN_BITS),
    .POS_BITS (POS_BITS),
    .ENTRY_W  (ENTRY_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .elem         (elem),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready),
    .pos_o        (pos)
  );

  cce_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  cce_back #(
    .LEN_BITS (LEN_BITS),
    .POS_BITS (POS_BITS),
    .ENTRY_W  (ENTRY_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .piece       (piece)
  );

`include "assert_macros.svh"

  `ASSERT_CLK(a_marker_ends_string, (piece.valid && !piece.piece_valid) |-> (piece.string_end && piece.run_last && (piece.piece_len == '0)), "end-only marker is not the end of a string")
  `ASSERT_CLK(a_final_clears_pos, (elem.valid && elem.ready && elem.elem_final) |=> (pos == '0), "read position not cleared after a final element")
  `ASSERT_CLK(a_start_written, (psel && penable && pwrite && (paddr[3:2] == REG_CLIP_START)) |=> (cfg.clip_start == $past(pwdata)), "clip_start not taken from the write transfer")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cce_pkg::*;

  localparam logic [ELEM_OP_W-1:0] OP_UNDEF_LO = 4'd9;
  localparam logic [ELEM_OP_W-1:0] OP_UNDEF_HI = 4'd15;
  localparam logic [ELEM_LEN_W-1:0] LEN_MAX = '1;
  localparam logic [CFG_W-1:0] POS_TOP = '1;
  localparam int unsigned RANDOM_ITEMS = 450;

  typedef struct packed {
    logic [ELEM_OP_W-1:0]  op;
    logic [ELEM_LEN_W-1:0] len;
    logic                  fin;
  } elem_t;

  typedef struct packed {
    logic                  pv;
    logic [ELEM_OP_W-1:0]  op;
    logic [ELEM_LEN_W-1:0] len;
    logic                  rl;
    logic                  se;
  } piece_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  cce_elem_if  elem_ch ();
  cce_piece_if piece_ch ();

  cigar_clip_elements i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .elem    (elem_ch),
    .piece   (piece_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  elem_t  elem_pending [$];
  piece_t piece_exp [$];

  logic [CFG_W-1:0] cfg_start;
  logic [CFG_W-1:0] cfg_stop;
  logic             cfg_hard;
  logic [CFG_W-1:0] read_pos;

  int err_count;
  int n_random;
  int src_wait;
  int snk_wait;
  bit quiet;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic bit takes_bases(logic [ELEM_OP_W-1:0] op);
    case (op)
      OP_MATCH, OP_INS, OP_SOFT, OP_EQUAL, OP_DIFF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic piece_t mk_piece(logic [ELEM_OP_W-1:0] op, logic [ELEM_LEN_W-1:0] len);
    return '{1'b1, op, len, 1'b0, 1'b0};
  endfunction

  function automatic void predict_pieces(elem_t it);
    piece_t res [2];
    int n;
    logic [CFG_W-1:0] s;
    logic [CFG_W-1:0] e;
    logic [CFG_W-1:0] kept;
    logic [CFG_W:0] sum;
    logic eats;
    logic whole;
    logic left;
    logic [ELEM_OP_W-1:0] clip_op;
    n = 0;
    clip_op = cfg_hard ? OP_HARD : OP_SOFT;
    left = (cfg_start == '0);
    if (it.op == OP_HARD) begin
      res[n] = mk_piece(it.op, it.len);
      n++;
    end else begin
      s = read_pos;
      e = s;
      eats = takes_bases(it.op);
      if (eats) begin
        sum = {1'b0, s} + {{(CFG_W + 1 - ELEM_LEN_W){1'b0}}, it.len};
        e = sum[CFG_W] ? POS_TOP : sum[CFG_W-1:0];
      end
      if (e <= cfg_start || s >= cfg_stop) begin
        if (eats || (s != cfg_start && s != cfg_stop)) begin
          res[n] = mk_piece(it.op, it.len);
          n++;
        end
      end else begin
        if (left) begin
          whole = (e <= cfg_stop);
          kept = e - cfg_stop;
        end else begin
          whole = (cfg_start <= s);
          kept = cfg_start - s;
        end
        if (whole) begin
          if (eats) begin
            res[n] = mk_piece(clip_op, it.len);
            n++;
          end
        end else if (left) begin
          res[0] = mk_piece(clip_op, it.len - kept[ELEM_LEN_W-1:0]);
          res[1] = mk_piece(it.op, kept[ELEM_LEN_W-1:0]);
          n = 2;
        end else begin
          res[0] = mk_piece(it.op, kept[ELEM_LEN_W-1:0]);
          res[1] = mk_piece(clip_op, it.len - kept[ELEM_LEN_W-1:0]);
          n = 2;
        end
      end
      read_pos = e;
    end
    if (it.fin) begin
      if (n == 0) begin
        res[0] = '0;
        n = 1;
      end
      res[n-1].se = 1'b1;
      read_pos = '0;
    end
    if (n > 0) begin
      res[n-1].rl = 1'b1;
    end
    for (int k = 0; k < n; k++) begin
      piece_exp.push_back(res[k]);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (elem_ch.valid && elem_ch.ready) begin
        predict_pieces('{elem_ch.elem_op, elem_ch.elem_len, elem_ch.elem_final});
      end
      if (!elem_ch.valid || elem_ch.ready) begin
        if (src_wait != 0 || elem_pending.size() == 0) begin
          elem_ch.valid <= 1'b0;
          if (src_wait != 0) begin
            src_wait <= src_wait - 1;
          end
        end else begin
          elem_ch.elem_op    <= elem_pending[0].op;
          elem_ch.elem_len   <= elem_pending[0].len;
          elem_ch.elem_final <= elem_pending[0].fin;
          elem_ch.valid      <= 1'b1;
          void'(elem_pending.pop_front());
          src_wait <= quiet ? 0 : $urandom_range(0, 3);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    piece_t want;
    int w;
    if (rst_ni) begin
      if (piece_ch.valid && piece_ch.ready) begin
        if (piece_exp.size() == 0) begin
          $error("unexpected piece: op %0d len %0h", piece_ch.piece_op, piece_ch.piece_len);
          err_count++;
        end else begin
          want = piece_exp.pop_front();
          check_field("piece_valid", 32'(want.pv), 32'(piece_ch.piece_valid));
          check_field("piece_op", 32'(want.op), 32'(piece_ch.piece_op));
          check_field("piece_len", 32'(want.len), 32'(piece_ch.piece_len));
          check_field("run_last", 32'(want.rl), 32'(piece_ch.run_last));
          check_field("string_end", 32'(want.se), 32'(piece_ch.string_end));
        end
        w = quiet ? 0 : $urandom_range(0, 3);
        snk_wait <= w;
        piece_ch.ready <= (w == 0);
      end else if (snk_wait != 0) begin
        snk_wait <= snk_wait - 1;
        piece_ch.ready <= (snk_wait == 1);
      end else begin
        piece_ch.ready <= 1'b1;
      end
    end
  end

  task automatic reg_write(reg_idx_e idx, logic [CFG_W-1:0] val);
    logic [APB_DATA_W-1:0] readback;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_CLIP_START: cfg_start = val;
      REG_CLIP_STOP:  cfg_stop = val;
      REG_CLIP_HARD:  cfg_hard = val[0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_CLIP_START: readback = cfg_start;
      REG_CLIP_STOP:  readback = cfg_stop;
      default:        readback = {{(APB_DATA_W - 1){1'b0}}, cfg_hard};
    endcase
    check_field("prdata", readback, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_window(logic [CFG_W-1:0] start, logic [CFG_W-1:0] stop, logic hard);
    reg_write(REG_CLIP_START, start);
    reg_write(REG_CLIP_STOP, stop);
    reg_write(REG_CLIP_HARD, {{(CFG_W - 1){1'b0}}, hard});
  endtask

  task automatic wait_idle();
    while (elem_pending.size() != 0 || elem_ch.valid || piece_exp.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_elem(logic [ELEM_OP_W-1:0] op, logic [ELEM_LEN_W-1:0] len, logic fin);
    elem_pending.push_back('{op, len, fin});
  endtask

  function automatic logic [ELEM_LEN_W-1:0] rand_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return ELEM_LEN_W'($urandom_range(0, 24));
    if (r < 80) return ELEM_LEN_W'($urandom_range(0, 300));
    if (r < 95) return ELEM_LEN_W'($urandom());
    return LEN_MAX;
  endfunction

  function automatic logic [ELEM_OP_W-1:0] rand_op();
    if ($urandom_range(0, 9) == 0) return ELEM_OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    return ELEM_OP_W'($urandom_range(OP_MATCH, OP_DIFF));
  endfunction

  task automatic push_string(int n_elems, int n_long);
    for (int k = 0; k < n_long; k++) begin
      push_elem(OP_MATCH, LEN_MAX, 1'b0);
    end
    for (int k = 1; k <= n_elems; k++) begin
      push_elem(rand_op(), rand_len(), k == n_elems);
    end
    n_random += n_long + n_elems;
  endtask

  initial begin
    logic [CFG_W-1:0] start;
    logic [CFG_W-1:0] stop;
    int mode;
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    elem_ch.valid = 1'b0;
    elem_ch.elem_op = OP_NONE;
    elem_ch.elem_len = '0;
    elem_ch.elem_final = 1'b0;
    piece_ch.ready = 1'b0;
    cfg_start = '0;
    cfg_stop = '0;
    cfg_hard = 1'b0;
    read_pos = '0;
    err_count = 0;
    n_random = 0;
    src_wait = 0;
    snk_wait = 0;
    quiet = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    push_elem(OP_MATCH, LEN_MAX, 1'b0);
    push_elem(OP_DEL, '0, 1'b1);
    push_elem(OP_HARD, LEN_MAX, 1'b1);
    wait_idle();

    set_window('0, 32'd10, 1'b0);
    push_elem(OP_SOFT, 28'd2, 1'b0);
    push_elem(OP_HARD, 28'd5, 1'b0);
    push_elem(OP_MATCH, 28'd6, 1'b0);
    push_elem(OP_DEL, 28'd1, 1'b0);
    push_elem(OP_DIFF, 28'd4, 1'b0);
    push_elem(OP_DEL, 28'd3, 1'b0);
    push_elem(OP_EQUAL, 28'd3, 1'b1);
    push_elem(OP_MATCH, 28'd10, 1'b0);
    push_elem(OP_SKIP, 28'd4, 1'b0);
    push_elem(OP_PAD, 28'd1, 1'b1);
    push_elem(OP_UNDEF_LO, '0, 1'b0);
    push_elem(OP_UNDEF_HI, LEN_MAX, 1'b1);
    wait_idle();

    set_window(32'd5, 32'd9, 1'b1);
    push_elem(OP_MATCH, 28'd3, 1'b0);
    push_elem(OP_DEL, 28'd1, 1'b0);
    push_elem(OP_INS, 28'd4, 1'b0);
    push_elem(OP_HARD, 28'd7, 1'b0);
    push_elem(OP_DEL, 28'd2, 1'b0);
    push_elem(OP_MATCH, 28'd1, 1'b0);
    push_elem(OP_MATCH, 28'd5, 1'b1);
    push_elem(OP_MATCH, 28'd5, 1'b0);
    push_elem(OP_DEL, 28'd2, 1'b0);
    push_elem(OP_MATCH, 28'd9, 1'b1);
    wait_idle();

    set_window(POS_TOP - $urandom_range(0, 40), POS_TOP, 1'b0);
    push_string($urandom_range(1, 3), 16);
    push_string($urandom_range(1, 3), 16);
    wait_idle();
    set_window('0, POS_TOP, 1'b1);
    push_string($urandom_range(1, 3), 16);
    wait_idle();
    set_window(POS_TOP, POS_TOP, 1'b0);
    push_string($urandom_range(1, 3), 16);
    wait_idle();

    while (n_random < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 9);
      if (mode < 3) begin
        start = '0;
        stop = $urandom_range(0, 120);
      end else if (mode < 6) begin
        start = $urandom_range(1, 120);
        stop = start + $urandom_range(0, 120);
      end else if (mode < 7) begin
        start = $urandom_range(20, 150);
        stop = $urandom_range(0, start - 1);
      end else if (mode < 9) begin
        start = $urandom();
        stop = $urandom();
      end else begin
        start = '0;
        stop = POS_TOP;
      end
      set_window(start, stop, 1'($urandom_range(0, 1)));
      quiet = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 8)) push_string($urandom_range(1, 8), 0);
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/cce_pkg.sv
hw/rtl/cce_if.sv
hw/rtl/cce_regs.sv
hw/rtl/cce_front.sv
hw/rtl/cce_fifo.sv
hw/rtl/cce_back.sv
hw/rtl/cigar_clip_elements.sv
tb/sv/tb_top.sv
